// ===== hw/rtl/lzbd_pkg.sv =====
// ----------------------------------------------------------------------------
// LZ byte token decompressor package
// Shared widths, command codes and status codes.
// ----------------------------------------------------------------------------
package lzbd_pkg;

   localparam int BYTE_W            = 8;
   localparam int STATUS_W          = 2;
   localparam int OFFSET_W          = 23;
   localparam int LENGTH_W          = 9;
   localparam int CMP_W             = 24;
   localparam int HISTORY_DEPTH_DEF = 65536;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_COPY = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_REFUSED    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_OFFSET = 2'd2;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

// ===== hw/rtl/lzbd_if.sv =====
// ----------------------------------------------------------------------------
// LZ byte token decompressor channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lzbd_req_if import lzbd_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     command;
   byte_type in_byte;

   modport source (output valid, output command, output in_byte, input ready);
   modport sink   (input valid, input command, input in_byte, output ready);
endinterface

interface lzbd_rsp_if import lzbd_pkg::*; ();
   logic                valid;
   logic                ready;
   byte_type            out_byte;
   logic                out_valid;
   logic                copy_active;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output out_byte, output out_valid, output copy_active,
                   output status, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input copy_active,
                   input status, output ready);
endinterface

// ===== hw/rtl/lz_byte_token_decompressor.sv =====
// Latency: a result is valid on the cycle after its item is accepted.
// Throughput: one item per cycle unless the response side stalls, set by the
// single history memory port pair (one write, one registered read per cycle,
// with forwarding of the last write). Reset: synchronous, clears parser state,
// counters and the result stage; the history memory is not cleared.
// ----------------------------------------------------------------------------
// LZ byte token decompressor
// Parses literal and match tokens and replays matches from a history memory.
// ----------------------------------------------------------------------------
module lz_byte_token_decompressor
   import lzbd_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lzbd_req_if.sink  req_chan,
   lzbd_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int PW = $clog2(HISTORY_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
   localparam logic [PW-1:0] FULL_CNT  = PW'(HISTORY_DEPTH);

   localparam logic [2:0] PH_HEADER   = 3'd0;
   localparam logic [2:0] PH_LITERALS = 3'd1;
   localparam logic [2:0] PH_LEN_EXT  = 3'd2;
   localparam logic [2:0] PH_OFF0     = 3'd3;
   localparam logic [2:0] PH_OFF1     = 3'd4;
   localparam logic [2:0] PH_OFF2     = 3'd5;

   byte_type hist_mem [HISTORY_DEPTH];
   byte_type rd_ff;

   logic [2:0]          phase_ff, phase_in;
   logic [7:0]          lit_left_ff, lit_left_in;
   logic [LENGTH_W-1:0] match_len_ff, match_len_in;
   logic [OFFSET_W-1:0] match_off_ff, match_off_in;
   logic                long_off_ff, long_off_in;
   logic [LENGTH_W-1:0] copy_left_ff, copy_left_in;
   logic [AW-1:0]       src_ff, src_in;
   logic [AW-1:0]       wp_ff, wp_in;
   logic [PW-1:0]       prod_ff, prod_in;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_pend_ff, s1_pend_in;
   logic                s1_we_ff, s1_we_in;
   logic                s1_copy_ff, s1_copy_in;
   logic                s1_fwd_ff, s1_fwd_in;
   byte_type            s1_fwd_data_ff, s1_fwd_data_in;
   byte_type            s1_lit_ff, s1_lit_in;
   logic [AW-1:0]       s1_waddr_ff, s1_waddr_in;
   logic                s1_ovalid_ff, s1_ovalid_in;
   logic                s1_active_ff, s1_active_in;
   logic [STATUS_W-1:0] s1_status_ff, s1_status_in;

   logic                accept;
   logic                rd_en;
   logic                produce;
   byte_type            s1_data;
   byte_type            b;
   logic [OFFSET_W-1:0] off_new;
   logic                finish;
   logic [CMP_W-1:0]    src_diff;

   assign accept          = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = !s1_valid_ff || rsp_chan.ready;
   assign b               = req_chan.in_byte;
   assign s1_data         = s1_copy_ff ? (s1_fwd_ff ? s1_fwd_data_ff : rd_ff) : s1_lit_ff;

   assign rsp_chan.valid       = s1_valid_ff;
   assign rsp_chan.out_byte    = s1_ovalid_ff ? s1_data : '0;
   assign rsp_chan.out_valid   = s1_ovalid_ff;
   assign rsp_chan.copy_active = s1_active_ff;
   assign rsp_chan.status      = s1_status_ff;

   always_comb begin
      phase_in       = phase_ff;
      lit_left_in    = lit_left_ff;
      match_len_in   = match_len_ff;
      match_off_in   = match_off_ff;
      long_off_in    = long_off_ff;
      copy_left_in   = copy_left_ff;
      src_in         = src_ff;
      wp_in          = wp_ff;
      prod_in        = prod_ff;
      rd_en          = 1'b0;
      produce        = 1'b0;
      finish         = 1'b0;
      off_new        = OFFSET_W'({match_off_ff, b});
      src_diff       = '0;
      s1_we_in       = 1'b0;
      s1_copy_in     = 1'b0;
      s1_fwd_in      = s1_we_ff && (s1_waddr_ff == src_ff);
      s1_fwd_data_in = s1_data;
      s1_lit_in      = b;
      s1_waddr_in    = wp_ff;
      s1_ovalid_in   = 1'b0;
      s1_status_in   = STAT_OK;

      if (accept) begin
         if (req_chan.command == CMD_COPY) begin
            if (copy_left_ff != '0) begin
               rd_en        = 1'b1;
               produce      = 1'b1;
               s1_copy_in   = 1'b1;
               s1_we_in     = 1'b1;
               s1_ovalid_in = 1'b1;
               copy_left_in = copy_left_ff - 1'b1;
               src_in       = (src_ff == LAST_ADDR) ? '0 : src_ff + 1'b1;
            end
         end else if (copy_left_ff != '0) begin
            s1_status_in = STAT_REFUSED;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  if (!b[7]) begin
                     lit_left_in = b + 8'd1;
                     phase_in    = PH_LITERALS;
                  end else if (b[6:0] == 7'h7f) begin
                     match_len_in = LENGTH_W'(8'h7f);
                     phase_in     = PH_LEN_EXT;
                  end else begin
                     match_len_in = LENGTH_W'(b[6:0]) + LENGTH_W'(3);
                     phase_in     = PH_OFF0;
                  end
               end
               PH_LITERALS: begin
                  produce      = 1'b1;
                  s1_we_in     = 1'b1;
                  s1_ovalid_in = 1'b1;
                  if (lit_left_ff != '0) begin
                     lit_left_in = lit_left_ff - 1'b1;
                  end
                  if (lit_left_ff <= 8'd1) begin
                     phase_in = PH_HEADER;
                  end
               end
               PH_LEN_EXT: begin
                  match_len_in = LENGTH_W'(8'h7f) + LENGTH_W'(b) + LENGTH_W'(3);
                  phase_in     = PH_OFF0;
               end
               PH_OFF0: begin
                  long_off_in  = b[7];
                  match_off_in = OFFSET_W'(b[6:0]);
                  phase_in     = PH_OFF1;
               end
               PH_OFF1: begin
                  match_off_in = off_new;
                  if (long_off_ff) begin
                     phase_in = PH_OFF2;
                  end else begin
                     finish = 1'b1;
                  end
               end
               PH_OFF2: begin
                  match_off_in = off_new;
                  finish       = 1'b1;
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase

            if (finish) begin
               phase_in = PH_HEADER;
               if (off_new == '0 || CMP_W'(off_new) > CMP_W'(prod_ff)) begin
                  s1_status_in = STAT_BAD_OFFSET;
               end else begin
                  copy_left_in = match_len_ff;
                  src_diff     = CMP_W'(wp_ff) - CMP_W'(off_new);
                  if (CMP_W'(wp_ff) < CMP_W'(off_new)) begin
                     src_diff = src_diff + CMP_W'(HISTORY_DEPTH);
                  end
                  src_in = src_diff[AW-1:0];
               end
            end
         end

         if (produce) begin
            wp_in = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
            if (prod_ff != FULL_CNT) begin
               prod_in = prod_ff + 1'b1;
            end
         end
      end

      s1_active_in = copy_left_in != '0;
      s1_pend_in   = accept && s1_we_in;
      s1_valid_in  = accept ? 1'b1 : (rsp_chan.ready ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (s1_pend_ff) begin
         hist_mem[s1_waddr_ff] <= s1_data;
      end
      if (rd_en) begin
         rd_ff <= hist_mem[src_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         lit_left_ff  <= '0;
         match_len_ff <= '0;
         match_off_ff <= '0;
         long_off_ff  <= 1'b0;
         copy_left_ff <= '0;
         src_ff       <= '0;
         wp_ff        <= '0;
         prod_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s1_pend_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         lit_left_ff  <= lit_left_in;
         match_len_ff <= match_len_in;
         match_off_ff <= match_off_in;
         long_off_ff  <= long_off_in;
         copy_left_ff <= copy_left_in;
         src_ff       <= src_in;
         wp_ff        <= wp_in;
         prod_ff      <= prod_in;
         s1_valid_ff  <= s1_valid_in;
         s1_pend_ff   <= s1_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_we_ff       <= s1_we_in;
         s1_copy_ff     <= s1_copy_in;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= s1_fwd_data_in;
         s1_lit_ff      <= s1_lit_in;
         s1_waddr_ff    <= s1_waddr_in;
         s1_ovalid_ff   <= s1_ovalid_in;
         s1_active_ff   <= s1_active_in;
         s1_status_ff   <= s1_status_in;
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ byte token decompressor testbench
// Walks a short table of directed tokens, then random well-formed and broken
// token streams under three backpressure mixes. Every output is checked field
// by field against a table row or a behavioral decoder of the accepted items.
// ----------------------------------------------------------------------------
module tb_top import lzbd_pkg::*; ();

   localparam int HIST_DEPTH  = HISTORY_DEPTH_DEF;
   localparam int HIST_AW     = $clog2(HIST_DEPTH);
   localparam int RAND_ITEMS  = 550;
   localparam int MAX_REPORTS = 10;

   typedef enum logic [2:0] {
      TOK_HEADER,
      TOK_LITERAL,
      TOK_LEN_EXT,
      TOK_OFF_HI,
      TOK_OFF_MID,
      TOK_OFF_LO
   } tok_phase_type;

   typedef struct packed {
      byte_type            out_byte;
      logic                out_valid;
      logic                copy_active;
      logic [STATUS_W-1:0] status;
   } out_item_type;

   typedef struct packed {
      logic         cmd;
      byte_type     data;
      logic         fixed;
      out_item_type res;
   } dir_row_type;

   localparam out_item_type NO_OUTPUT = '{8'h00, 1'b0, 1'b0, STAT_OK};

   logic clock;
   logic reset = 1'b1;

   lzbd_req_if req_if ();
   lzbd_rsp_if rsp_if ();

   lz_byte_token_decompressor #(
      .HISTORY_DEPTH(HIST_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   // decoder state
   byte_type            hist_mem [HIST_DEPTH];
   tok_phase_type       tok_phase = TOK_HEADER;
   logic [7:0]          lit_left  = '0;
   logic [LENGTH_W-1:0] match_len = '0;
   logic [LENGTH_W-1:0] copy_left = '0;
   logic [OFFSET_W-1:0] match_off = '0;
   logic                long_off  = 1'b0;
   logic [HIST_AW-1:0]  copy_src  = '0;
   logic [HIST_AW-1:0]  wr_pos    = '0;
   logic [HIST_AW:0]    produced  = '0;

   out_item_type pending_outputs [$];
   out_item_type want;
   int           mismatches   = 0;
   int           out_count    = 0;
   int           stream_items = 0;
   int           send_idle    = 37;
   int           recv_idle    = 60;

   dir_row_type dir_table [24] = '{
      '{CMD_COPY, 8'h00, 1'b1, NO_OUTPUT},
      '{CMD_PUSH, 8'h80, 1'b1, NO_OUTPUT},
      '{CMD_PUSH, 8'h00, 1'b1, NO_OUTPUT},
      '{CMD_PUSH, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, STAT_BAD_OFFSET}},
      '{CMD_PUSH, 8'h01, 1'b0, '0},
      '{CMD_PUSH, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, STAT_OK}},
      '{CMD_PUSH, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, STAT_OK}},
      '{CMD_PUSH, 8'hFE, 1'b0, '0},
      '{CMD_PUSH, 8'h7F, 1'b0, '0},
      '{CMD_PUSH, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, STAT_BAD_OFFSET}},
      '{CMD_PUSH, 8'hFF, 1'b0, '0},
      '{CMD_PUSH, 8'hFF, 1'b0, '0},
      '{CMD_PUSH, 8'hFF, 1'b0, '0},
      '{CMD_PUSH, 8'hFF, 1'b0, '0},
      '{CMD_PUSH, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, STAT_BAD_OFFSET}},
      '{CMD_PUSH, 8'h80, 1'b0, '0},
      '{CMD_PUSH, 8'h80, 1'b0, '0},
      '{CMD_PUSH, 8'h00, 1'b0, '0},
      '{CMD_PUSH, 8'h01, 1'b0, '0},
      '{CMD_PUSH, 8'hA5, 1'b1, '{8'h00, 1'b0, 1'b1, STAT_REFUSED}},
      '{CMD_COPY, 8'h00, 1'b0, '0},
      '{CMD_COPY, 8'hFF, 1'b0, '0},
      '{CMD_COPY, 8'h5A, 1'b0, '0},
      '{CMD_COPY, 8'h00, 1'b1, NO_OUTPUT}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic record_byte(input byte_type b);
      hist_mem[wr_pos] = b;
      wr_pos = wr_pos + 1'b1;
      if (produced < HIST_DEPTH) produced = produced + 1'b1;
   endtask

   task automatic close_match(output logic [STATUS_W-1:0] st);
      tok_phase = TOK_HEADER;
      if (match_off == 0 || match_off > produced) begin
         st = STAT_BAD_OFFSET;
      end else begin
         copy_left = match_len;
         copy_src  = wr_pos - match_off[HIST_AW-1:0];
         st        = STAT_OK;
      end
   endtask

   task automatic decompress_step(input logic cmd, input byte_type b, output out_item_type r);
      byte_type v;
      r = '0;
      if (cmd == CMD_COPY) begin
         if (copy_left != 0) begin
            v = hist_mem[copy_src];
            copy_src = copy_src + 1'b1;
            record_byte(v);
            copy_left   = copy_left - 1'b1;
            r.out_byte  = v;
            r.out_valid = 1'b1;
         end
      end else if (copy_left != 0) begin
         r.status = STAT_REFUSED;
      end else begin
         case (tok_phase)
            TOK_HEADER: begin
               if (!b[7]) begin
                  lit_left  = b + 8'd1;
                  tok_phase = TOK_LITERAL;
               end else if (b[6:0] == 7'h7f) begin
                  match_len = 9'h07f;
                  tok_phase = TOK_LEN_EXT;
               end else begin
                  match_len = b[6:0] + 9'd3;
                  tok_phase = TOK_OFF_HI;
               end
            end
            TOK_LITERAL: begin
               record_byte(b);
               r.out_byte  = b;
               r.out_valid = 1'b1;
               if (lit_left != 0) lit_left = lit_left - 1'b1;
               if (lit_left == 0) tok_phase = TOK_HEADER;
            end
            TOK_LEN_EXT: begin
               match_len = 9'h07f + b + 9'd3;
               tok_phase = TOK_OFF_HI;
            end
            TOK_OFF_HI: begin
               long_off  = b[7];
               match_off = {16'd0, b[6:0]};
               tok_phase = TOK_OFF_MID;
            end
            TOK_OFF_MID: begin
               match_off = {match_off[14:0], b};
               if (long_off) tok_phase = TOK_OFF_LO;
               else close_match(r.status);
            end
            TOK_OFF_LO: begin
               match_off = {match_off[14:0], b};
               close_match(r.status);
            end
            default: tok_phase = TOK_HEADER;
         endcase
      end
      r.copy_active = (copy_left != 0);
   endtask

   task automatic send_item(input logic cmd, input byte_type b,
                            input logic fixed = 1'b0, input out_item_type fixed_res = '0);
      out_item_type r;
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.in_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      if (!(cmd == CMD_COPY && copy_left == 0)) stream_items++;
      decompress_step(cmd, b, r);
      pending_outputs.push_back(fixed ? fixed_res : r);
      if ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
   endtask

   task automatic send_match_token(input logic [OFFSET_W-1:0] off, input int len);
      if (len > 129) begin
         send_item(CMD_PUSH, 8'hFF);
         send_item(CMD_PUSH, byte_type'(len - 130));
      end else begin
         send_item(CMD_PUSH, {1'b1, 7'(len - 3)});
      end
      if (off > 23'h7fff || $urandom_range(3) == 0) begin
         send_item(CMD_PUSH, {1'b1, off[22:16]});
         send_item(CMD_PUSH, off[15:8]);
      end else begin
         send_item(CMD_PUSH, {1'b0, off[14:8]});
      end
      send_item(CMD_PUSH, off[7:0]);
   endtask

   // drain any copy and bring the parser back to a token header
   task automatic settle_stream();
      while (copy_left != 0 || tok_phase != TOK_HEADER) begin
         if (copy_left != 0) begin
            if ($urandom_range(19) == 0) send_item(CMD_PUSH, byte_type'($urandom));
            send_item(CMD_COPY, byte_type'($urandom));
         end else begin
            send_item(CMD_PUSH, byte_type'($urandom));
         end
      end
   endtask

   task automatic random_stream(input int count);
      int                  target;
      int                  pick;
      int                  n;
      int                  len;
      int                  near;
      logic [OFFSET_W-1:0] off;
      target = stream_items + count;
      while (stream_items < target) begin
         pick = $urandom_range(99);
         if (pick < 40 || produced == 0) begin
            n = $urandom_range(19);
            if (n == 0) n = 128;
            else if (n < 3) n = $urandom_range(128, 1);
            else n = $urandom_range(6, 1);
            send_item(CMD_PUSH, byte_type'(n - 1));
            repeat (n) send_item(CMD_PUSH, byte_type'($urandom));
         end else if (pick < 80) begin
            if ($urandom_range(24) == 0)
               len = 130 + (($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15));
            else if ($urandom_range(9) == 0)
               len = $urandom_range(129, 3);
            else
               len = $urandom_range(12, 3);
            near = (produced < 16) ? int'(produced) : 16;
            if ($urandom_range(1) == 0) off = OFFSET_W'($urandom_range(near, 1));
            else off = OFFSET_W'($urandom_range(int'(produced), 1));
            send_match_token(off, len);
         end else if (pick < 88) begin
            if ($urandom_range(1) == 0) off = '0;
            else off = OFFSET_W'(int'(produced) + $urandom_range(1000, 1));
            send_match_token(off, $urandom_range(12, 3));
         end else if (pick < 94) begin
            send_item(CMD_COPY, byte_type'($urandom));
         end else begin
            repeat ($urandom_range(4, 1)) send_item(CMD_PUSH, byte_type'($urandom));
         end
         settle_stream();
      end
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         out_count++;
         if (pending_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("output item %0d unexpected: byte %02h valid %0b active %0b status %0d",
                        out_count, rsp_if.out_byte, rsp_if.out_valid, rsp_if.copy_active,
                        rsp_if.status);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_if.out_byte !== want.out_byte || rsp_if.out_valid !== want.out_valid ||
                rsp_if.copy_active !== want.copy_active || rsp_if.status !== want.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("output item %0d expected: byte %02h valid %0b active %0b status %0d",
                           out_count, want.out_byte, want.out_valid, want.copy_active,
                           want.status);
                  $display("output item %0d actual:   byte %02h valid %0b active %0b status %0d",
                           out_count, rsp_if.out_byte, rsp_if.out_valid, rsp_if.copy_active,
                           rsp_if.status);
               end
            end
         end
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.command = CMD_PUSH;
      req_if.in_byte = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         send_item(dir_table[i].cmd, dir_table[i].data, dir_table[i].fixed, dir_table[i].res);
      random_stream(RAND_ITEMS / 3);

      // hold off until the output side has drained
      req_if.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);

      send_idle = 60;
      recv_idle = 37;
      random_stream(RAND_ITEMS / 3);

      send_idle = 0;
      recv_idle = 0;
      random_stream(RAND_ITEMS / 3);

      req_if.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("lz_byte_token_decompressor: match");
      end else begin
         $display("lz_byte_token_decompressor: mismatch");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("lz_byte_token_decompressor: mismatch");
      $finish;
   end

endmodule

// ===== lz_byte_token_decompressor.f =====
hw/rtl/lzbd_pkg.sv
hw/rtl/lzbd_if.sv
hw/rtl/lz_byte_token_decompressor.sv
tb/tb_top.sv
